@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/ffc_pkg.sv @@
// Package: payload types and operation codes for the format converter.
`default_nettype none
package ffc_pkg;
	typedef enum logic [1:0] {
		KIND_I2X = 2'd0,
		KIND_F2X = 2'd1,
		KIND_X2I = 2'd2,
		KIND_X2F = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] operand;
	} req_t;

	typedef struct packed {
		logic [31:0] result;
		logic        overflow;
	} rsp_t;

	localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;
endpackage
`default_nettype wire

@@ rtl/fixed_float_format_converter.sv @@
// Top level: registered fixed/float/int format converter.
// channel | signals              | transfer
// request | start, busy, req     | start && !busy
// result  | done, rsp            | done
// One item per cycle; a result passes the input register, then the result register,
// before it is on the ports with done.
// busy is always low.
// arst_n clears the valid flags only; the receiver cannot stall.
`default_nettype none
`include "assert_macros.svh"
module fixed_float_format_converter import ffc_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      rsp
);
	req_t req_s1;
	logic vld_s1;
	rsp_t rsp_w;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s1 <= start;
			done <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= req;
		rsp <= rsp_w;
	end

	ffc_core #(.FRAC_BITS(FRAC_BITS)) u_core (.req(req_s1), .rsp(rsp_w));

	`ASSERT_NEXT(a_pipe, clk, arst_n, start, vld_s1)
	`ASSERT_NEXT(a_done, clk, arst_n, vld_s1, done)
	`ASSERT_IMPL(a_busy, clk, arst_n, 1'b1, !busy)
endmodule
`default_nettype wire

@@ rtl/ffc_core.sv @@
// Combinational conversion datapath for all four operations.
`default_nettype none
module ffc_core import ffc_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  wire req_t req,
	output rsp_t      rsp
);
	localparam int FB = FRAC_BITS;

	logic signed [31:0] op_s;
	logic [31:0] r_i2x, r_f2x, r_x2i, r_x2f;
	logic        o_i2x, o_f2x;

	// int to fixed
	logic signed [32+FB-1:0] i2x_w;
	always_comb begin
		i2x_w = {{FB{op_s[31]}}, op_s} <<< FB;
		o_i2x = (i2x_w[32+FB-1:31] != {(FB+1){1'b0}}) &&
			(i2x_w[32+FB-1:31] != {(FB+1){1'b1}});
		r_i2x = o_i2x ? (op_s[31] ? NEG_LIMIT : POS_LIMIT) : i2x_w[31:0];
	end
	assign op_s = req.operand;

	// float to fixed
	logic        f_neg;
	logic [7:0]  f_ef;
	logic [22:0] f_fr;
	logic [23:0] f_m;
	logic signed [9:0] f_sh;
	logic [5:0]  f_n;
	logic [63:0] f_big;
	logic [32:0] f_mag;
	logic        f_big_ovf;
	always_comb begin
		f_neg = req.operand[31];
		f_ef  = req.operand[30:23];
		f_fr  = req.operand[22:0];
		f_m   = {(f_ef != 8'd0), f_fr};
		f_sh  = (f_ef == 8'd0) ? 10'(-149 + FB) : 10'(signed'({2'b0, f_ef}) - 150 + FB);
		f_n   = 6'd0;
		f_big = 64'd0;
		f_mag = 33'd0;
		f_big_ovf = 1'b0;
		if (f_sh >= 0) begin
			if (f_sh >= 10'sd9) f_big_ovf = 1'b1;
			else begin
				f_big = {40'd0, f_m} << f_sh[3:0];
				f_mag = f_big[32:0];
			end
		end else begin
			f_n = 6'(-f_sh > 10'sd26 ? 10'sd26 : -f_sh);
			f_big = ({40'd0, f_m} + (64'd1 << (f_n - 6'd1))) >> f_n;
			f_mag = (f_n > 6'd25) ? 33'd0 : f_big[32:0];
		end
		o_f2x = 1'b0;
		if (f_ef == 8'hFF) begin
			o_f2x = 1'b1;
			r_f2x = (f_fr != 23'd0) ? 32'd0 : (f_neg ? NEG_LIMIT : POS_LIMIT);
		end else if (f_m == 24'd0) r_f2x = 32'd0;
		else if (f_big_ovf) begin
			o_f2x = 1'b1;
			r_f2x = f_neg ? NEG_LIMIT : POS_LIMIT;
		end else if (f_neg) begin
			if (f_mag > 33'h0_8000_0000) begin
				o_f2x = 1'b1;
				r_f2x = NEG_LIMIT;
			end else r_f2x = 32'(33'd0 - f_mag);
		end else begin
			if (f_mag > 33'h0_7FFF_FFFF) begin
				o_f2x = 1'b1;
				r_f2x = POS_LIMIT;
			end else r_f2x = f_mag[31:0];
		end
	end

	// fixed to int
	assign r_x2i = 32'(op_s >>> FB);

	// fixed to float
	logic [31:0] x_mag;
	logic [4:0]  x_p;
	logic [31:0] x_norm;
	logic [24:0] x_q;
	logic        x_rnd;
	logic [7:0]  x_ex;
	always_comb begin
		x_mag = op_s[31] ? 32'(-op_s) : req.operand;
		x_p = 5'd0;
		for (int i = 0; i < 32; i++)
			if (x_mag[i]) x_p = 5'(i);
		x_norm = x_mag << (5'd31 - x_p);
		x_rnd = x_norm[7] && (x_norm[8] || (x_norm[6:0] != 7'd0));
		x_q = {1'b0, x_norm[31:8]} + {24'd0, x_rnd};
		x_ex = 8'(6'(x_p) + 8'd127 - 8'(FB) + {7'd0, x_q[24]});
		if (x_mag == 32'd0) r_x2f = 32'd0;
		else r_x2f = {op_s[31], x_ex, x_q[24] ? x_q[23:1] : x_q[22:0]};
	end

	always_comb begin
		rsp.overflow = 1'b0;
		case (kind_t'(req.kind))
			KIND_I2X: begin
				rsp.result = r_i2x;
				rsp.overflow = o_i2x;
			end
			KIND_F2X: begin
				rsp.result = r_f2x;
				rsp.overflow = o_f2x;
			end
			KIND_X2I: rsp.result = r_x2i;
			default:  rsp.result = r_x2f;
		endcase
	end
endmodule
`default_nettype wire

@@ test/fixed_float_format_converter_checker.sv @@
// Checker for the format converter: predicts each result and compares it.
`timescale 1ns / 100ps
`default_nettype none
module fixed_float_format_converter_checker import ffc_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic busy,
	input  wire req_t req,
	input  wire logic done,
	input  wire rsp_t rsp,
	output int        fail_count,
	output int        pending
);
	rsp_t conv_queue[$];

	function automatic rsp_t sat_mag(input logic neg, input logic [63:0] mag);
		rsp_t r;
		r.overflow = 1'b0;
		if (neg) begin
			if (mag > 64'h8000_0000) begin
				r.result = NEG_LIMIT;
				r.overflow = 1'b1;
			end else
				r.result = 32'(64'd0 - mag);
		end else if (mag > 64'h7FFF_FFFF) begin
			r.result = POS_LIMIT;
			r.overflow = 1'b1;
		end else
			r.result = mag[31:0];
		return r;
	endfunction

	function automatic rsp_t convert(input req_t q);
		rsp_t r;
		logic signed [63:0] v;
		logic [63:0] m, mag, low, half, qv;
		logic neg;
		int e, sh, p;
		r.result = '0;
		r.overflow = 1'b0;
		case (kind_t'(q.kind))
			KIND_I2X: begin
				v = 64'(signed'(q.operand)) <<< FRAC_BITS;
				if (v > 64'sh7FFF_FFFF) begin
					r.result = POS_LIMIT;
					r.overflow = 1'b1;
				end else if (v < -64'sh8000_0000) begin
					r.result = NEG_LIMIT;
					r.overflow = 1'b1;
				end else
					r.result = v[31:0];
			end
			KIND_F2X: begin
				neg = q.operand[31];
				if (q.operand[30:23] == 8'hFF) begin
					r.overflow = 1'b1;
					if (q.operand[22:0] != 0) r.result = '0;
					else r.result = neg ? NEG_LIMIT : POS_LIMIT;
				end else begin
					if (q.operand[30:23] == 0) begin
						m = {41'd0, q.operand[22:0]};
						e = -149;
					end else begin
						m = {40'd0, 1'b1, q.operand[22:0]};
						e = int'(q.operand[30:23]) - 150;
					end
					if (m != 0) begin
						sh = e + FRAC_BITS;
						if (sh >= 40) begin
							r.overflow = 1'b1;
							r.result = neg ? NEG_LIMIT : POS_LIMIT;
						end else begin
							if (sh >= 0) mag = m << sh;
							else if (-sh > 25) mag = 0;
							else mag = (m + (64'd1 << (-sh - 1))) >> (-sh);
							r = sat_mag(neg, mag);
						end
					end
				end
			end
			KIND_X2I: r.result = 32'($signed(q.operand) >>> FRAC_BITS);
			default: begin
				neg = q.operand[31];
				v = 64'(signed'(q.operand));
				mag = neg ? 64'(-v) : 64'(v);
				if (mag != 0) begin
					p = 0;
					while (p < 40 && (mag >> (p + 1)) != 0) p++;
					if (p > 23) begin
						sh = p - 23;
						low = mag & ((64'd1 << sh) - 1);
						half = 64'd1 << (sh - 1);
						qv = mag >> sh;
						if (low > half || (low == half && qv[0])) qv++;
						if (qv == (64'd1 << 24)) begin
							qv = qv >> 1;
							p++;
						end
					end else
						qv = mag << (23 - p);
					r.result = {neg, 8'(p - FRAC_BITS + 127), qv[22:0]};
				end
			end
		endcase
		return r;
	endfunction

	assign pending = conv_queue.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			conv_queue.delete();
			fail_count <= 0;
		end else begin
			if (done) begin
				if (conv_queue.size() == 0) begin
					if (fail_count < 10) $display("unexpected result %h/%b", rsp.result, rsp.overflow);
					fail_count <= fail_count + 1;
				end else begin
					want = conv_queue.pop_front();
					if (rsp.result !== want.result || rsp.overflow !== want.overflow) begin
						if (fail_count < 10)
							$display("mismatch: expected %h/%b got %h/%b",
								want.result, want.overflow, rsp.result, rsp.overflow);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) conv_queue.push_back(convert(req));
		end
	end
endmodule
`default_nettype wire

@@ test/fixed_float_format_converter_test.sv @@
// Testbench top: drives operands into the format converter and reports the verdict.
`timescale 1ns / 100ps
`default_nettype none
module fixed_float_format_converter_test import ffc_pkg::*;;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy, done;
	rsp_t rsp;
	int fail_count, pending, idle_pct, quiet;
	localparam int QUIET_LIMIT = 2000;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	fixed_float_format_converter #(.FRAC_BITS(8)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	fixed_float_format_converter_checker #(.FRAC_BITS(8)) chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [31:0] rand_operand(input logic [1:0] k);
		logic [31:0] x;
		x = $urandom;
		case ($urandom_range(0, 5))
			0: x = $signed(x) >>> $urandom_range(0, 31);
			1: if (k == KIND_F2X) x[30:23] = 8'($urandom_range(100, 170));
			2: if (k == KIND_F2X) x[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			3: x = x >> $urandom_range(0, 31);
			default: ;
		endcase
		return x;
	endfunction

	task automatic send(input logic [1:0] k, input logic [31:0] op);
		while (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= '{kind: k, operand: op};
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	logic [31:0] edge_ops[] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
		32'h007F_FFFF, 32'hFF80_0000, 32'h7F80_0000, 32'h7FC0_0000, 32'h3F00_0000,
		32'h3B80_0000, 32'h4EFF_FFFF, 32'hFFFF_FF80, 32'h00FF_FFFF, 32'h0100_0001};

	initial begin
		int cnt;
		idle_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < 24; i++)
			send(2'(i % 4), edge_ops[i % edge_ops.size()]);
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 77 : (ph == 3 ? 20 : 0);
			for (cnt = 0; cnt < 400; cnt++) begin
				logic [1:0] k;
				k = 2'($urandom_range(0, 3));
				send(k, rand_operand(k));
			end
		end
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (fail_count == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
